>>> hdl/mtg_pkg.sv
package mtg_pkg;

	localparam int STATE_WORDS   = 624;
	localparam int MIDDLE_OFFSET = 397;
	localparam int ADDR_W        = $clog2(STATE_WORDS);
	localparam int WORD_W        = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

	// command codes
	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_NEXT = 1'b1;

	localparam word_t INIT_MULT  = 32'd1812433253;
	localparam word_t TWIST_XOR  = 32'h9908b0df;
	localparam word_t TEMPER_B   = 32'h9d2c5680;
	localparam word_t TEMPER_C   = 32'hefc60000;

	localparam addr_t LAST_IDX   = ADDR_W'(STATE_WORDS - 1);
	localparam addr_t WORDS_A    = ADDR_W'(STATE_WORDS);
	localparam addr_t MID_OFS    = ADDR_W'(MIDDLE_OFFSET);
	localparam addr_t FAR_SPLIT  = ADDR_W'(STATE_WORDS - MIDDLE_OFFSET);

	// access request to the state memory: one write and two reads per cycle
	typedef struct packed {
		logic  we;
		addr_t waddr;
		word_t wdata;
		logic  re_a;
		addr_t addr_a;
		logic  re_b;
		addr_t addr_b;
	} ram_req_t;

endpackage

>>> hdl/mtg_req_if.sv
interface mtg_req_if;
	logic                valid;
	logic                ready;
	logic                command;
	logic [31:0]         seed_value;

	modport source (output valid, output command, output seed_value, input ready);
	modport sink (input valid, input command, input seed_value, output ready);
endinterface

>>> hdl/mtg_rsp_if.sv
interface mtg_rsp_if;
	logic                valid;
	logic                ready;
	logic [31:0]         random_word;

	modport source (output valid, output random_word, input ready);
	modport sink (input valid, input random_word, output ready);
endinterface

>>> hdl/mtg_state_ram.sv
module mtg_state_ram (
	input  logic              clk,
	input  mtg_pkg::ram_req_t ctl,
	output mtg_pkg::word_t    rd_a,
	output mtg_pkg::word_t    rd_b
);

	mtg_pkg::word_t mem [mtg_pkg::STATE_WORDS];
	mtg_pkg::word_t rd_a_q;
	mtg_pkg::word_t rd_b_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		if (ctl.re_a) begin
			rd_a_q <= mem[ctl.addr_a];
		end
		if (ctl.re_b) begin
			rd_b_q <= mem[ctl.addr_b];
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

>>> hdl/mt19937_generator_core.sv
// MT19937 32-bit generator core.
// req channel (valid/ready): command 0 seeds the state from seed_value and gives
// no result; command 1 returns one tempered word on the rsp channel.
// A seed keeps the core busy: one 32x32 multiply and one add per state word
// after word 0, ST_SEED_M then ST_SEED_A, written to the 624-word state memory.
// A next accepted with words left is read through the memory's read register and
// tempered into the rsp output register in ST_RD_T; the core takes a new item once
// back in ST_IDLE. Every 624th next (and the first after a seed) twists the whole
// state first, each word through ST_TW_RD and ST_TW_WR and the memory's two read
// ports, before word 0 is tempered.
// rsp holds its word in an output register; the core accepts the next item
// while that word waits, and a second result waits in the core (req not ready)
// until the receiver takes the first.
// Reset clears the control state and marks the state for twisting; the state
// memory itself is not cleared, and a next before the first seed returns
// an undefined word.
module mt19937_generator_core (
	input  logic      clk,
	input  logic      arst_n,
	mtg_req_if.sink   req,
	mtg_rsp_if.source rsp
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEED_M = 3'd1;
	localparam logic [2:0] ST_SEED_A = 3'd2;
	localparam logic [2:0] ST_TW_RD  = 3'd3;
	localparam logic [2:0] ST_TW_WR  = 3'd4;
	localparam logic [2:0] ST_RD_T   = 3'd5;

	function automatic mtg_pkg::word_t temper(input mtg_pkg::word_t y_in);
		mtg_pkg::word_t y;
		y = y_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	logic [2:0]        state_q;
	mtg_pkg::addr_t    idx_q;
	mtg_pkg::addr_t    pos_q;
	logic              out_valid_q;
	mtg_pkg::word_t    out_word_q;
	mtg_pkg::word_t    prev_q;
	mtg_pkg::word_t    prod_q;
	mtg_pkg::word_t    cur_q;

	mtg_pkg::ram_req_t ram_req;
	mtg_pkg::word_t    rd_a;
	mtg_pkg::word_t    rd_b;

	logic              accept;
	logic              out_space;
	logic              twist_due;
	mtg_pkg::word_t    seed_sum;
	mtg_pkg::word_t    twist_y;
	mtg_pkg::word_t    twisted;
	mtg_pkg::addr_t    nxt_idx;
	mtg_pkg::addr_t    far_idx;

	assign req.ready   = (state_q == ST_IDLE);
	assign accept      = req.valid && req.ready;
	assign out_space   = !out_valid_q || rsp.ready;
	assign twist_due   = (pos_q >= mtg_pkg::WORDS_A);
	assign rsp.valid   = out_valid_q;
	assign rsp.random_word = out_word_q;

	assign seed_sum = prod_q + mtg_pkg::WORD_W'(idx_q);
	assign nxt_idx  = (idx_q == mtg_pkg::LAST_IDX) ? '0 : idx_q + 1'b1;
	assign far_idx  = (idx_q < mtg_pkg::FAR_SPLIT) ? idx_q + mtg_pkg::MID_OFS
	                                               : idx_q - mtg_pkg::FAR_SPLIT;
	// upper bit of w[i], lower bits of w[i+1]
	assign twist_y  = {cur_q[mtg_pkg::WORD_W-1], rd_a[mtg_pkg::WORD_W-2:0]};
	assign twisted  = rd_b ^ (twist_y >> 1) ^ (twist_y[0] ? mtg_pkg::TWIST_XOR : '0);

	always_comb begin
		ram_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.command == mtg_pkg::CMD_SEED) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = '0;
						ram_req.wdata = req.seed_value;
					end else begin
						ram_req.re_a   = 1'b1;
						ram_req.addr_a = twist_due ? '0 : pos_q;
					end
				end
			end
			ST_SEED_A: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q;
				ram_req.wdata = seed_sum;
			end
			ST_TW_RD: begin
				ram_req.re_a   = 1'b1;
				ram_req.addr_a = nxt_idx;
				ram_req.re_b   = 1'b1;
				ram_req.addr_b = far_idx;
			end
			ST_TW_WR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q;
				ram_req.wdata = twisted;
				// last word twisted: fetch word 0 for output
				if (idx_q == mtg_pkg::LAST_IDX) begin
					ram_req.re_a   = 1'b1;
					ram_req.addr_a = '0;
				end
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	mtg_state_ram u_state_ram (
		.clk  (clk),
		.ctl  (ram_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			pos_q       <= mtg_pkg::WORDS_A;
			out_valid_q <= 1'b0;
		end else begin
			// a word loaded in this cycle keeps valid high
			if (out_valid_q && rsp.ready && !(state_q == ST_RD_T && out_space)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (req.command == mtg_pkg::CMD_SEED) begin
							state_q <= ST_SEED_M;
						end else if (twist_due) begin
							state_q <= ST_TW_RD;
						end else begin
							pos_q   <= pos_q + 1'b1;
							state_q <= ST_RD_T;
						end
					end
				end
				ST_SEED_M: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_SEED_A;
				end
				ST_SEED_A: begin
					if (idx_q == mtg_pkg::LAST_IDX) begin
						pos_q   <= mtg_pkg::WORDS_A;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SEED_M;
					end
				end
				ST_TW_RD: begin
					state_q <= ST_TW_WR;
				end
				ST_TW_WR: begin
					if (idx_q == mtg_pkg::LAST_IDX) begin
						pos_q   <= mtg_pkg::ADDR_W'(1);
						state_q <= ST_RD_T;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_TW_RD;
					end
				end
				ST_RD_T: begin
					if (out_space) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_q <= req.seed_value;
		end else if (state_q == ST_SEED_A) begin
			prev_q <= seed_sum;
		end
		if (state_q == ST_SEED_M) begin
			prod_q <= mtg_pkg::INIT_MULT * (prev_q ^ (prev_q >> 30));
		end
		if (state_q == ST_TW_RD) begin
			cur_q <= rd_a;
		end
		if (state_q == ST_RD_T && out_space) begin
			out_word_q <= temper(rd_a);
		end
	end

`ifndef SYNTHESIS
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (ram_req.waddr < mtg_pkg::WORDS_A))
		else $error("state write beyond last word");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= mtg_pkg::WORDS_A)
		else $error("read position past state size");

	a_twist_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TW_WR && idx_q == mtg_pkg::LAST_IDX) |=> (pos_q == mtg_pkg::ADDR_W'(1)))
		else $error("read position not restarted after twist");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_T && out_space) |=> (rsp.valid && state_q == ST_IDLE))
		else $error("tempered word not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> (out_valid_q && $stable(out_word_q)))
		else $error("pending result overwritten");
`endif

endmodule
